// ===== src/ialist_pkg.sv =====
`default_nettype none
package ialist_pkg;

	localparam int POS_W  = 7;
	localparam int WORD_W = 32;
	localparam int OP_W   = 3;
	localparam int STAT_W = 3;

	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
	localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_INDEX  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL       = 3'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY_DUMP = 3'd3;
	localparam logic [STAT_W-1:0] STAT_BAD_OPCODE = 3'd4;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_ROTATE,
		CMD_INSERT,
		CMD_DELETE,
		CMD_UPDATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} ctrl_state_t;

endpackage
`default_nettype wire

// ===== src/ialist_cell.sv =====
`default_nettype none
module ialist_cell (
	input  wire logic                       clk,
	input  wire logic [ialist_pkg::POS_W-1:0]  idx,
	input  wire ialist_pkg::cell_ctl_t      ctl,
	input  wire logic [ialist_pkg::WORD_W-1:0] left,
	input  wire logic [ialist_pkg::WORD_W-1:0] right,
	output logic      [ialist_pkg::WORD_W-1:0] word
);
	import ialist_pkg::*;

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_HOLD: begin
				word_q <= word_q;
			end
			CMD_ROTATE: begin
				word_q <= right;
			end
			CMD_INSERT: begin
				// later cells take the word from below, the addressed one the new word
				if (idx > ctl.pos) begin
					word_q <= left;
				end else if (idx == ctl.pos) begin
					word_q <= ctl.word;
				end
			end
			CMD_DELETE: begin
				if (idx >= ctl.pos) begin
					word_q <= right;
				end
			end
			CMD_UPDATE: begin
				if (idx == ctl.pos) begin
					word_q <= ctl.word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign word = word_q;

endmodule
`default_nettype wire

// ===== src/ialist_ctrl.sv =====
`default_nettype none
module ialist_ctrl #(
	parameter int CAPACITY = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ialist_pkg::OP_W-1:0]   opcode,
	input  wire logic [ialist_pkg::POS_W-1:0]  position,
	input  wire logic [ialist_pkg::WORD_W-1:0] new_word,
	input  wire logic [ialist_pkg::WORD_W-1:0] head_word,
	output ialist_pkg::cell_ctl_t              ctl,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ialist_pkg::STAT_W-1:0] status,
	output logic      [ialist_pkg::WORD_W-1:0] read_word,
	output logic      [ialist_pkg::POS_W-1:0]  length_now,
	output logic                               last_of_run
);
	import ialist_pkg::*;

	localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [KW-1:0]    K_LAST = KW'(CAPACITY - 1);
	localparam logic [POS_W-1:0] CAP_N  = POS_W'(CAPACITY);

	ctrl_state_t       state_q, state_d;
	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;
	logic [POS_W-1:0]  count_q, count_d;
	logic [KW-1:0]     k_q, k_d;
	logic [POS_W-1:0]  k_ext;

	logic              ov_q;
	logic [STAT_W-1:0] ostat_q;
	logic [WORD_W-1:0] oword_q;
	logic [POS_W-1:0]  olen_q;
	logic              olast_q;

	logic              out_free;
	logic              load;
	logic [STAT_W-1:0] ld_stat;
	logic [WORD_W-1:0] ld_word;
	logic              ld_last;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign k_ext    = POS_W'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		k_d      = k_q;
		ctl.cmd  = CMD_HOLD;
		ctl.pos  = pos_q;
		ctl.word = word_q;
		load     = 1'b0;
		ld_stat  = STAT_OK;
		ld_word  = '0;
		ld_last  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					unique case (op_q)
						OP_READ: begin
							if (pos_q < count_q) begin
								load    = 1'b0;
								k_d     = '0;
								state_d = S_SCAN;
							end else begin
								ld_stat = STAT_BAD_INDEX;
							end
						end
						OP_INSERT: begin
							// position is checked before the fill level
							if (pos_q > count_q) begin
								ld_stat = STAT_BAD_INDEX;
							end else if (count_q >= CAP_N) begin
								ld_stat = STAT_FULL;
							end else begin
								ctl.cmd = CMD_INSERT;
								count_d = count_q + 1'b1;
							end
						end
						OP_DELETE: begin
							if (pos_q < count_q) begin
								ctl.cmd = CMD_DELETE;
								count_d = count_q - 1'b1;
							end else begin
								ld_stat = STAT_BAD_INDEX;
							end
						end
						OP_UPDATE: begin
							if (pos_q < count_q) begin
								ctl.cmd = CMD_UPDATE;
							end else begin
								ld_stat = STAT_BAD_INDEX;
							end
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								ld_stat = STAT_EMPTY_DUMP;
							end else begin
								load    = 1'b0;
								k_d     = '0;
								state_d = S_SCAN;
							end
						end
						default: begin
							ld_stat = STAT_BAD_OPCODE;
						end
					endcase
				end
			end
			S_SCAN: begin
				// one full revolution of the chain; cell 0 holds element k
				if (out_free) begin
					ctl.cmd = CMD_ROTATE;
					k_d     = k_q + 1'b1;
					ld_word = head_word;
					if (op_q == OP_READ) begin
						load = (k_ext == pos_q);
					end else begin
						load    = (k_ext < count_q);
						ld_last = ((k_ext + 1'b1) == count_q);
					end
					if (k_q == K_LAST) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			count_q <= count_d;
			k_q     <= k_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode;
			pos_q  <= position;
			word_q <= new_word;
		end
		if (load) begin
			ostat_q <= ld_stat;
			oword_q <= ld_word;
			olen_q  <= count_d;
			olast_q <= ld_last;
		end
	end

	assign out_valid   = ov_q;
	assign status      = ostat_q;
	assign read_word   = oword_q;
	assign length_now  = olen_q;
	assign last_of_run = olast_q;

endmodule
`default_nettype wire

// ===== src/indexed_array_list_engine_top.sv =====
// ordered list of signed 32-bit words held in a ring of CAPACITY cells
// input items arrive on s_tvalid/s_tready/s_tdata: opcode, position, new_word
// result items leave on m_tvalid/m_tready/m_tdata with m_tlast
// insert, delete and update act on all affected cells at once; on insert and
// delete the moved cells take their neighbour's word, update writes one cell
// read and dump rotate the ring one full turn, one cell per cycle while the
// output is not stalled, with cell 0 presenting element k on step k; the ring
// is back in place at the end; an item's work starts in the cycle after it is
// taken; insert, delete, update, errors: the result is registered from the
// exec state, which waits while the output is stalled, and the next item is
// taken after that; for read and dump it waits for the full ring turn; a dump
// gives one result per stored word, last one flagged on m_tlast
// a stalled m_tready holds the ring turn; the result register keeps its item
// reset clears the count and the handshake state; cell contents are not reset
// and only ever read below the count
`default_nettype none
module indexed_array_list_engine_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[2:0], position[9:3], new_word[41:10], zero pad
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[2:0], read_word[34:3], length_now[41:35], zero pad
	output logic      [47:0] m_tdata,
	output logic             m_tlast
);
	import ialist_pkg::*;

	logic [WORD_W-1:0] cells [CAPACITY];
	cell_ctl_t         ctl;
	logic [STAT_W-1:0] status;
	logic [WORD_W-1:0] read_word;
	logic [POS_W-1:0]  length_now;

	ialist_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.opcode     (s_tdata[2:0]),
		.position   (s_tdata[9:3]),
		.new_word   (s_tdata[41:10]),
		.head_word  (cells[0]),
		.ctl        (ctl),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.status     (status),
		.read_word  (read_word),
		.length_now (length_now),
		.last_of_run(m_tlast)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ialist_cell u_cell (
			.clk  (clk),
			.idx  (POS_W'(i)),
			.ctl  (ctl),
			.left (cells[(i + CAPACITY - 1) % CAPACITY]),
			.right(cells[(i + 1) % CAPACITY]),
			.word (cells[i])
		);
	end

	assign m_tdata = {6'd0, length_now, read_word, status};

endmodule
`default_nettype wire
